[hw/rtl/ppc_pkg.sv]
// ppc_pkg: constants, types and cordic angle table for polar_pose_controller
// no dependencies
package ppc_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 5;
  localparam int AngW = 34;
  localparam int CxW = 30;
  localparam int SqW = 50;
  localparam int RhoW = 25;
  localparam int AccW = 64;

  localparam logic [2:0] RegGoalX = 3'd0;
  localparam logic [2:0] RegGoalY = 3'd1;
  localparam logic [2:0] RegGoalHeading = 3'd2;
  localparam logic [2:0] RegGainRho = 3'd3;
  localparam logic [2:0] RegGainAlpha = 3'd4;
  localparam logic [2:0] RegGainBeta = 3'd5;
  localparam logic [2:0] RegEnable = 3'd6;

  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [17:0] Ang3Deg = 18'sd546;
  localparam logic [SqW-1:0] RhoSqLimit = 50'd1717986;
  localparam logic signed [17:0] KRho = 18'sd113778;
  localparam logic signed [17:0] KAng = 18'sd83998;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_VEC, ST_SQX, ST_SQY, ST_DECIDE, ST_SQRT,
    ST_MUL, ST_SUM, ST_OUT
  } state_t;

  function automatic logic [31:0] atan_at(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_at = 32'd536870912;
      5'd1: atan_at = 32'd316933406;
      5'd2: atan_at = 32'd167458907;
      5'd3: atan_at = 32'd85004756;
      5'd4: atan_at = 32'd42667331;
      5'd5: atan_at = 32'd21354465;
      5'd6: atan_at = 32'd10680862;
      5'd7: atan_at = 32'd5340245;
      5'd8: atan_at = 32'd2670163;
      5'd9: atan_at = 32'd1335087;
      5'd10: atan_at = 32'd667544;
      5'd11: atan_at = 32'd333772;
      5'd12: atan_at = 32'd166886;
      5'd13: atan_at = 32'd83443;
      5'd14: atan_at = 32'd41722;
      5'd15: atan_at = 32'd20861;
      5'd16: atan_at = 32'd10430;
      5'd17: atan_at = 32'd5215;
      5'd18: atan_at = 32'd2608;
      5'd19: atan_at = 32'd1304;
      5'd20: atan_at = 32'd652;
      5'd21: atan_at = 32'd326;
      5'd22: atan_at = 32'd163;
      5'd23: atan_at = 32'd81;
      default: atan_at = 32'd0;
    endcase
  endfunction

endpackage

[hw/rtl/ppc_if.sv]
// ppc_if: valid/ready channel interfaces for pose input and speed output
// depends on nothing
interface ppc_pose_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic signed [15:0] pose_heading;
  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface ppc_speed_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [19:0] right_speed;
  logic signed [19:0] left_speed;
  logic arrived;
  modport source (output valid, right_speed, left_speed, arrived, input ready);
  modport sink (input valid, right_speed, left_speed, arrived, output ready);
endinterface

[hw/rtl/polar_pose_controller.sv]
// polar_pose_controller: polar pose controller, cordic rotate/vector, sqrt, speed mix
// depends on ppc_pkg and ppc_if
//
// channel   dir  handshake     payload
// in        in   valid/ready   pose_x, pose_y, pose_heading
// out       out  valid/ready   right_speed, left_speed, arrived
// cfg       in   we only       index 3b, data 24b
//
// an enabled pose runs accept, rotation and vectoring cordic steps on the shared
// adder pair, squares and arrival test, one-bit-per-cycle square root, MUL, SUM and
// out; an arrival skips to out after the test, a disabled or arrived pose goes from
// accept to out. a pose is taken while the last result waits in the output register;
// a new result holds in the out state until that register is free.
// reset is synchronous
module polar_pose_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  ppc_pose_if.sink          in_ch,
  ppc_speed_if.source       out_ch
);

  localparam int CxW = ppc_pkg::CxW;
  localparam int AngW = ppc_pkg::AngW;
  localparam int SqW = ppc_pkg::SqW;
  localparam int RhoW = ppc_pkg::RhoW;
  localparam int AccW = ppc_pkg::AccW;

  logic signed [23:0] goal_x_r, goal_y_r;
  logic signed [15:0] goal_h_r, g_rho_r, g_alpha_r, g_beta_r;
  logic enable_r, done_r;

  ppc_pkg::state_t state_r, state_nxt;
  logic [ppc_pkg::StepW-1:0] step_r;

  logic signed [CxW-1:0] x_r, y_r;
  logic signed [AngW-1:0] z_r;
  logic signed [24:0] ex_r, ey_r;
  logic signed [15:0] ph_r;
  logic [SqW-1:0] sq_r, rem_r;
  logic [RhoW-1:0] root_r;
  logic signed [18:0] beta_r;
  logic signed [18:0] alpha_r;
  logic signed [41:0] prho_r;
  logic signed [34:0] pang_r;
  logic signed [AccW-1:0] rt_r, rs_r;
  logic signed [19:0] rsp_r, lsp_r;
  logic arr_r, wk_arr_r, ovalid_r;
  logic out_free;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= '0; goal_y_r <= '0; goal_h_r <= '0;
      g_rho_r <= 16'sd2048; g_alpha_r <= 16'sd6144; g_beta_r <= -16'sd2048;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppc_pkg::RegGoalX: goal_x_r <= cfg_data;
        ppc_pkg::RegGoalY: goal_y_r <= cfg_data;
        ppc_pkg::RegGoalHeading: goal_h_r <= cfg_data[15:0];
        ppc_pkg::RegGainRho: g_rho_r <= cfg_data[15:0];
        ppc_pkg::RegGainAlpha: g_alpha_r <= cfg_data[15:0];
        ppc_pkg::RegGainBeta: g_beta_r <= cfg_data[15:0];
        ppc_pkg::RegEnable: enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // cordic helpers
  logic signed [CxW-1:0] xs, ys;
  logic [31:0] atn;
  logic signed [AngW-1:0] vz_round;
  logic signed [18:0] beta_c, alpha_c;
  logic signed [15:0] theta_c;
  logic in_3deg;
  logic signed [AccW-1:0] rs_sum, ls_sum;

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    atn = ppc_pkg::atan_at(step_r);
    vz_round = (z_r + AngW'(32768)) >>> 16;
    beta_c = -19'(vz_round);
    theta_c = ph_r - goal_h_r;
    alpha_c = -beta_c - 19'(theta_c);
    in_3deg = (beta_c <= 19'(ppc_pkg::Ang3Deg)) && (beta_c >= -19'(ppc_pkg::Ang3Deg))
           && (alpha_c <= 19'(ppc_pkg::Ang3Deg)) && (alpha_c >= -19'(ppc_pkg::Ang3Deg));
    rs_sum = rt_r + rs_r + AccW'(64'sd2147483648);
    ls_sum = rt_r - rs_r + AccW'(64'sd2147483648);
  end

  // sqrt: one result bit per cycle, restoring, two remainder bits shifted in
  logic [SqW+1:0] sq_rem_sh;
  logic [SqW+1:0] sq_try;
  always_comb begin
    sq_rem_sh = {rem_r, sq_r[SqW-1:SqW-2]};
    sq_try = {root_r, 2'b01};
  end

  assign out_free = !ovalid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppc_pkg::ST_IDLE: if (in_ch.valid)
        state_nxt = (enable_r && !done_r) ? ppc_pkg::ST_ROT : ppc_pkg::ST_OUT;
      ppc_pkg::ST_ROT: if (step_r == ppc_pkg::StepW'(ppc_pkg::CordicSteps - 1))
        state_nxt = ppc_pkg::ST_VEC;
      ppc_pkg::ST_VEC: if (step_r == ppc_pkg::StepW'(ppc_pkg::CordicSteps - 1))
        state_nxt = ppc_pkg::ST_SQX;
      ppc_pkg::ST_SQX: state_nxt = ppc_pkg::ST_SQY;
      ppc_pkg::ST_SQY: state_nxt = ppc_pkg::ST_DECIDE;
      ppc_pkg::ST_DECIDE: state_nxt = (in_3deg && sq_r <= ppc_pkg::RhoSqLimit) ?
                                      ppc_pkg::ST_OUT : ppc_pkg::ST_SQRT;
      ppc_pkg::ST_SQRT: if (step_r == ppc_pkg::StepW'(RhoW - 1)) state_nxt = ppc_pkg::ST_MUL;
      ppc_pkg::ST_MUL: state_nxt = ppc_pkg::ST_SUM;
      ppc_pkg::ST_SUM: state_nxt = ppc_pkg::ST_OUT;
      ppc_pkg::ST_OUT: if (out_free) state_nxt = ppc_pkg::ST_IDLE;
      default: state_nxt = ppc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ppc_pkg::ST_IDLE);
    out_ch.valid = ovalid_r;
    out_ch.right_speed = rsp_r;
    out_ch.left_speed = lsp_r;
    out_ch.arrived = arr_r;
  end

  logic cfg_restart;
  assign cfg_restart = cfg_we && (cfg_index == ppc_pkg::RegGoalX ||
    cfg_index == ppc_pkg::RegGoalY || cfg_index == ppc_pkg::RegGoalHeading ||
    cfg_index == ppc_pkg::RegEnable);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppc_pkg::ST_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
      ovalid_r <= 1'b0;
      arr_r <= 1'b1;
      wk_arr_r <= 1'b1;
      rsp_r <= '0;
      lsp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_restart) begin
        done_r <= 1'b0;
      end else if (state_r == ppc_pkg::ST_DECIDE && in_3deg &&
                   sq_r <= ppc_pkg::RhoSqLimit) begin
        done_r <= 1'b1;
      end
      if (state_r == ppc_pkg::ST_OUT && out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ppc_pkg::ST_IDLE: begin
          step_r <= '0;
          if (in_ch.valid) begin
            wk_arr_r <= 1'b1;
            ex_r <= 25'(in_ch.pose_x) - 25'(goal_x_r);
            ey_r <= 25'(in_ch.pose_y) - 25'(goal_y_r);
            ph_r <= in_ch.pose_heading;
            // quarter-turn prerotation on z = -goal_heading*65536
            if (-(AngW'(goal_h_r) <<< 16) > ppc_pkg::QuarterTurn) begin
              x_r <= CxW'(25'(in_ch.pose_y) - 25'(goal_y_r));
              y_r <= -CxW'(25'(in_ch.pose_x) - 25'(goal_x_r));
              z_r <= -(AngW'(goal_h_r) <<< 16) - ppc_pkg::QuarterTurn;
            end else if (-(AngW'(goal_h_r) <<< 16) < -ppc_pkg::QuarterTurn) begin
              x_r <= -CxW'(25'(in_ch.pose_y) - 25'(goal_y_r));
              y_r <= CxW'(25'(in_ch.pose_x) - 25'(goal_x_r));
              z_r <= -(AngW'(goal_h_r) <<< 16) + ppc_pkg::QuarterTurn;
            end else begin
              x_r <= -CxW'(25'(in_ch.pose_x) - 25'(goal_x_r));
              y_r <= -CxW'(25'(in_ch.pose_y) - 25'(goal_y_r));
              z_r <= -(AngW'(goal_h_r) <<< 16);
            end
          end
        end
        ppc_pkg::ST_ROT: begin
          if (step_r == ppc_pkg::StepW'(ppc_pkg::CordicSteps - 1)) begin
            step_r <= '0;
            z_r <= '0;
            // finish last step, then force nonzero x and fold to right half plane
            begin
              logic signed [CxW-1:0] nx, ny;
              nx = (z_r >= 0) ? x_r - ys : x_r + ys;
              ny = (z_r >= 0) ? y_r + xs : y_r - xs;
              if (nx == '0) nx = CxW'(1);
              x_r <= (nx > 0) ? nx : -nx;
              y_r <= (nx > 0) ? ny : -ny;
            end
          end else begin
            step_r <= step_r + 1'b1;
            if (z_r >= 0) begin
              x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - AngW'(atn);
            end else begin
              x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + AngW'(atn);
            end
          end
        end
        ppc_pkg::ST_VEC: begin
          step_r <= (step_r == ppc_pkg::StepW'(ppc_pkg::CordicSteps - 1)) ?
                    '0 : step_r + 1'b1;
          if (y_r > 0) begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + AngW'(atn);
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - AngW'(atn);
          end
        end
        ppc_pkg::ST_SQX: sq_r <= SqW'(ex_r * ex_r);
        ppc_pkg::ST_SQY: sq_r <= sq_r + SqW'(ey_r * ey_r);
        ppc_pkg::ST_DECIDE: begin
          beta_r <= beta_c;
          alpha_r <= alpha_c;
          rem_r <= '0;
          root_r <= '0;
          step_r <= '0;
        end
        ppc_pkg::ST_SQRT: begin
          step_r <= step_r + 1'b1;
          sq_r <= sq_r << 2;
          if (sq_rem_sh >= sq_try) begin
            rem_r <= SqW'(sq_rem_sh - sq_try);
            root_r <= {root_r[RhoW-2:0], 1'b1};
          end else begin
            rem_r <= SqW'(sq_rem_sh);
            root_r <= {root_r[RhoW-2:0], 1'b0};
          end
        end
        ppc_pkg::ST_MUL: begin
          prho_r <= $signed({1'b0, root_r}) * g_rho_r;
          pang_r <= alpha_r * g_alpha_r + beta_r * g_beta_r;
        end
        ppc_pkg::ST_SUM: begin
          rt_r <= prho_r * ppc_pkg::KRho;
          rs_r <= pang_r * ppc_pkg::KAng;
          wk_arr_r <= 1'b0;
        end
        ppc_pkg::ST_OUT: begin
          if (out_free) begin
            arr_r <= wk_arr_r;
            if (wk_arr_r) begin
              rsp_r <= '0;
              lsp_r <= '0;
            end else begin
              rsp_r <= ((rs_sum >>> 32) > 64'sd524287) ? 20'sd524287 :
                       ((rs_sum >>> 32) < -64'sd524288) ? -20'sd524288 : 20'(rs_sum >>> 32);
              lsp_r <= ((ls_sum >>> 32) > 64'sd524287) ? 20'sd524287 :
                       ((ls_sum >>> 32) < -64'sd524288) ? -20'sd524288 : 20'(ls_sum >>> 32);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
